// File: rtl/core/ktfi_pkg.sv
// Shared types and constants for the key table find-or-insert block.
package ktfi_pkg;

   localparam int WORD_W    = 32;
   localparam int KEY_WORDS = 8;
   localparam int KEY_W     = WORD_W * KEY_WORDS;
   localparam int OUTCOME_W = 2;
   localparam int SLOT_W    = 5;
   localparam int RSP_W     = 8;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_FOUND    = 2'd0,
      OUTCOME_INSERTED = 2'd1,
      OUTCOME_FULL     = 2'd2
   } outcome_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_key;
      logic rd_en;
      logic check;
      logic advance;
      logic wr_en;
      logic set_full;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic match;
      logic last;
      logic have_empty;
   } status_type;

endpackage

// File: rtl/core/ktfi_datapath.sv
// Datapath: key register, record memory, scan index, fill count and result registers.
module ktfi_datapath
   import ktfi_pkg::*;
#(
   parameter int RECORDS       = 32,
   parameter int WORDS_PER_KEY = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [KEY_W-1:0]     key_in,
   output logic [OUTCOME_W-1:0] rsp_outcome,
   output logic [SLOT_W-1:0]    rsp_slot
);

   localparam int ROW_W  = WORDS_PER_KEY * WORD_W;
   localparam int IDX_W  = (RECORDS > 1) ? $clog2(RECORDS) : 1;
   localparam int FILL_W = $clog2(RECORDS + 1);

   logic [ROW_W-1:0] mem [RECORDS];

   logic [ROW_W-1:0]     key_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     idx_in;
   logic [FILL_W-1:0]    fill_ff;
   logic [FILL_W-1:0]    fill_in;
   logic [ROW_W-1:0]     rd_data_ff;
   logic                 rd_live_ff;
   logic [IDX_W-1:0]     empty_idx_ff;
   logic [IDX_W-1:0]     empty_idx_in;
   logic                 have_empty_ff;
   logic                 have_empty_in;
   outcome_type          res_outcome_ff;
   outcome_type          res_outcome_in;
   logic [SLOT_W-1:0]    res_slot_ff;
   logic [SLOT_W-1:0]    res_slot_in;
   logic [OUTCOME_W-1:0] rsp_outcome_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;

   logic [ROW_W-1:0] row;
   logic             row_match;
   logic             row_empty;

   // Rows at or above the fill count were never written and read as zero.
   assign row       = rd_live_ff ? rd_data_ff : '0;
   assign row_match = (row == key_ff);
   assign row_empty = (row[WORD_W-1:0] == '0);

   assign status.match      = row_match;
   assign status.last       = (idx_ff == IDX_W'(RECORDS - 1));
   assign status.have_empty = have_empty_ff | row_empty;

   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_slot    = rsp_slot_ff;

   always_comb begin
      idx_in         = idx_ff;
      fill_in        = fill_ff;
      empty_idx_in   = empty_idx_ff;
      have_empty_in  = have_empty_ff;
      res_outcome_in = res_outcome_ff;
      res_slot_in    = res_slot_ff;
      if (cmd.load_key) begin
         idx_in        = '0;
         have_empty_in = 1'b0;
      end
      if (cmd.check) begin
         if (row_match) begin
            res_outcome_in = OUTCOME_FOUND;
            res_slot_in    = SLOT_W'(idx_ff);
         end else if (row_empty && !have_empty_ff) begin
            empty_idx_in  = idx_ff;
            have_empty_in = 1'b1;
         end
      end
      if (cmd.advance) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.wr_en) begin
         res_outcome_in = OUTCOME_INSERTED;
         res_slot_in    = SLOT_W'(empty_idx_ff);
         if (FILL_W'(empty_idx_ff) == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cmd.set_full) begin
         res_outcome_in = OUTCOME_FULL;
         res_slot_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         have_empty_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         have_empty_ff <= have_empty_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      empty_idx_ff   <= empty_idx_in;
      res_outcome_ff <= res_outcome_in;
      res_slot_ff    <= res_slot_in;
      if (cmd.load_key) begin
         key_ff <= key_in[ROW_W-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_outcome_ff <= res_outcome_ff;
         rsp_slot_ff    <= res_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[empty_idx_ff] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[idx_ff];
         rd_live_ff <= (FILL_W'(idx_ff) < fill_ff);
      end
   end

endmodule

// File: rtl/core/ktfi_ctrl.sv
// Controller: sequences the record scan, the insert write and the result beat.
module ktfi_ctrl
   import ktfi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_key = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.match) begin
               state_in = ST_DONE;
            end else if (status.last) begin
               if (status.have_empty) begin
                  state_in = ST_WRITE;
               end else begin
                  cmd.set_full = 1'b1;
                  state_in     = ST_DONE;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_WRITE: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // The result waits here until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/key_table_find_or_insert.sv
// Top level of the key table find-or-insert block.
//
// The req channel takes one key per beat: eight 32-bit words in req_tdata.
// The block scans the records in index order and returns one rsp beat per
// key: found with the first matching index, inserted with the index of the
// first record whose word 0 is zero, or full with index zero.
// Each record is scanned as a registered memory read (ST_READ), then a compare
// (ST_CHECK). The scan of a key stops at its first matching record; a key that
// matches none goes through every record, and an insert then adds a write
// state (ST_WRITE) before the result is loaded.
// A new key is taken once the previous result is in the output register; a
// stalled rsp channel holds that beat, and the next result waits inside.
// Reset empties the table at once through a fill count: rows never written
// read as zero, so no clearing pass is needed, and the block is ready in the
// first cycle after reset.
module key_table_find_or_insert
   import ktfi_pkg::*;
#(
   parameter int RECORDS       = 32,
   parameter int WORDS_PER_KEY = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // key_word_0 .. key_word_7, 32 bits each
   input  logic [KEY_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // outcome [1:0], slot_index [6:2], zero [7]
   output logic [RSP_W-1:0] rsp_tdata
);

   cmd_type              cmd;
   status_type           status;
   logic [OUTCOME_W-1:0] rsp_outcome;
   logic [SLOT_W-1:0]    rsp_slot;

   assign rsp_tdata = {{(RSP_W - OUTCOME_W - SLOT_W){1'b0}}, rsp_slot, rsp_outcome};

   ktfi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ktfi_datapath #(
      .RECORDS       (RECORDS),
      .WORDS_PER_KEY (WORDS_PER_KEY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .key_in      (req_tdata),
      .rsp_outcome (rsp_outcome),
      .rsp_slot    (rsp_slot)
   );

endmodule

// File: sim/key_table_find_or_insert_tb.sv
// Self-checking testbench for the key table find-or-insert block.
module key_table_find_or_insert_tb;
   import ktfi_pkg::*;

   localparam int TABLE_RECORDS = 32;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int TAIL_CYCLES   = 100;
   localparam int PHASE_ITEMS   = 450;

   typedef struct packed {
      outcome_type           outcome;
      logic [SLOT_W-1:0]     slot;
   } lookup_result_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [KEY_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // Mirror of the record store, one 256-bit key per record, word 0 lowest.
   logic [KEY_W-1:0]  key_store [TABLE_RECORDS];
   lookup_result_type pending_lookups [$];

   int          send_idle_pct  = 28;
   int          recv_stall_pct = 61;
   int          mismatches     = 0;
   int unsigned cycle_count    = 0;

   key_table_find_or_insert dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Finds the key or claims the first record with word 0 clear for it.
   function automatic lookup_result_type lookup_or_store(input logic [KEY_W-1:0] key);
      lookup_result_type res;
      int found_at;
      int free_at;
      found_at = -1;
      free_at  = -1;
      for (int r = 0; r < TABLE_RECORDS; r++) begin
         if (found_at < 0 && key_store[r] == key) found_at = r;
         if (free_at < 0 && key_store[r][WORD_W-1:0] == '0) free_at = r;
      end
      if (found_at >= 0) begin
         res.outcome = OUTCOME_FOUND;
         res.slot    = found_at[SLOT_W-1:0];
      end else if (free_at >= 0) begin
         key_store[free_at] = key;
         res.outcome = OUTCOME_INSERTED;
         res.slot    = free_at[SLOT_W-1:0];
      end else begin
         res.outcome = OUTCOME_FULL;
         res.slot    = '0;
      end
      return res;
   endfunction

   function automatic bit store_has_free_record();
      for (int r = 0; r < TABLE_RECORDS; r++)
         if (key_store[r][WORD_W-1:0] == '0) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      for (int w = 0; w < KEY_WORDS; w++) k[w*WORD_W +: WORD_W] = $urandom;
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] key_of_words(input logic [WORD_W-1:0] w0,
                                                     input logic [WORD_W-1:0] rest);
      logic [KEY_W-1:0] k;
      for (int w = 1; w < KEY_WORDS; w++) k[w*WORD_W +: WORD_W] = rest;
      k[WORD_W-1:0] = w0;
      return k;
   endfunction

   // Drives one key and records its expected result once the beat is taken.
   task automatic send_key(input logic [KEY_W-1:0] key);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      pending_lookups.push_back(lookup_or_store(key));
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_cleared_table();
      send_key('0);                               // matches cleared record 0
      send_key('1);                               // inserted at 0
      send_key('1);                               // found at 0
      send_key('0);                               // now matches record 1
      wait_for_results();
   endtask

   task automatic test_word0_zero_keys();
      logic [KEY_W-1:0] k1;
      logic [KEY_W-1:0] k2;
      k1 = key_of_words('0, '1);
      k2 = '0;
      k2[KEY_W-1] = 1'b1;
      send_key(k1);                               // stored, record still counts as empty
      send_key(k1);                               // found like any other record
      send_key('0);                               // next all-zero record
      send_key(k2);                               // overwrites k1
      send_key(k1);                               // k1 is gone, overwrites k2
      send_key(k2);
      wait_for_results();
   endtask

   task automatic test_field_extremes();
      logic [KEY_W-1:0] k;
      send_key(key_of_words(32'h0000_0001, '0));
      send_key(key_of_words(32'h8000_0000, '0));
      send_key(key_of_words(32'hAAAA_AAAA, 32'h5555_5555));
      send_key(key_of_words(32'h5555_5555, 32'hAAAA_AAAA));
      send_key(key_of_words(32'h0120_6407, 32'h0120_6408));
      send_key(key_of_words(32'h0120_6408, 32'h0120_6407));
      send_key(key_of_words(32'h0000_0001, '0));
      k = '1;
      k[(KEY_WORDS-1)*WORD_W] = 1'b0;               // differs from all ones in word 7 only
      send_key(k);
      send_key(key_of_words(32'h0120_6407, 32'h0120_6408));
      wait_for_results();
   endtask

   // Mostly lookups of stored keys and keys that keep word 0 clear, so the
   // table fills slowly and inserts land across many records.
   task automatic test_random_traffic(input int items);
      logic [KEY_W-1:0] k;
      int kind;
      int w;
      for (int i = 0; i < items; i++) begin
         kind = $urandom_range(0, 99);
         k = key_store[$urandom_range(0, TABLE_RECORDS-1)];
         if (kind < 42) begin
            // repeat of a stored key
         end else if (kind < 70) begin
            k = random_key();
            k[WORD_W-1:0] = '0;
         end else if (kind < 86) begin
            w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, KEY_WORDS-1);
            k[w*WORD_W + $urandom_range(0, WORD_W-1)] ^= 1'b1;
         end else if (kind < 92) begin
            k = '0;
         end else if (kind < 96) begin
            k = random_key();
         end else begin
            k = key_of_words($urandom, $urandom_range(0, 1) ? '0 : '1);
         end
         send_key(k);
      end
      wait_for_results();
   endtask

   task automatic test_table_full();
      logic [KEY_W-1:0] k;
      while (store_has_free_record()) begin
         k = random_key();
         if (k[WORD_W-1:0] == '0) k[0] = 1'b1;
         send_key(k);
      end
      send_key(random_key());                     // no room left
      send_key('0);                               // no all-zero record remains
      send_key(key_of_words('0, 32'h1234_5678));
      send_key(key_store[TABLE_RECORDS-1]);       // highest index still found
      send_key(key_store[0]);
      wait_for_results();
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[key_table_find_or_insert] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected rsp beat, expected none, actual %h",
                     $time, rsp_tdata);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_tdata[1:0] !== want.outcome || rsp_tdata[6:2] !== want.slot) begin
               mismatches++;
               $display("%0t: expected outcome %0d slot %0d, actual outcome %0d slot %0d",
                        $time, want.outcome, want.slot, rsp_tdata[1:0], rsp_tdata[6:2]);
            end
         end
      end
   end

   initial begin
      for (int r = 0; r < TABLE_RECORDS; r++) key_store[r] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_cleared_table();
      test_word0_zero_keys();
      test_field_extremes();
      test_random_traffic(PHASE_ITEMS);

      send_idle_pct  = 61;
      recv_stall_pct = 28;
      test_random_traffic(PHASE_ITEMS);
      test_table_full();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_traffic(PHASE_ITEMS);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_lookups.size() != 0) begin
         mismatches++;
         $display("%0t: expected %0d more rsp beats, actual none", $time,
                  pending_lookups.size());
      end
      if (mismatches == 0)
         $display("[key_table_find_or_insert] OK");
      else
         $display("[key_table_find_or_insert] ERROR");
      $finish;
   end

endmodule
